FILE: rtl/crx_pkg.sv
`default_nettype none
package crx_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned IndexW     = 7;
  localparam int unsigned PaddrW     = 3;

  localparam logic [WordW-1:0] OffsetStep = 32'h561A9C1A;
  localparam logic [WordW-1:0] SeedMark   = 32'h8B12BAB6;
  localparam logic [WordW-1:0] BlockBytes = 32'd512;
  localparam int unsigned      KeyRot     = 10;
  localparam int unsigned      ChainRot   = 15;
  localparam int unsigned      OffsetRot  = 7;
  localparam int unsigned      OffsetRot2 = 2;
  localparam logic [IndexW-1:0] LastIndex = 7'd127;

  // register index, taken from paddr[2]
  localparam logic RegMode = 1'b0;
  localparam logic RegSeed = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] seed;
  } cfg_t;

  // block setup values precomputed for the next block position
  typedef struct packed {
    logic [WordW-1:0] mix;
    logic [WordW-1:0] off;
  } setup_t;

  // events from the core that move the next-block position
  typedef struct packed {
    logic start;
    logic adv;
  } blk_evt_t;

  typedef struct packed {
    logic              in_full;
    logic [IndexW-1:0] word_index;
  } core_stat_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/crx_if.sv
`default_nettype none
interface crx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        stream_start;

  modport source (output valid, output data_word, output stream_start, input ready);
  modport sink   (input valid, input data_word, input stream_start, output ready);
endinterface

interface crx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        block_end;

  modport source (output valid, output result_word, output block_end, input ready);
  modport sink   (input valid, input result_word, input block_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/crx_regs.sv
`default_nettype none
module crx_regs
  import crx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // register writes, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= 1'b0;
      cfg.seed <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        RegMode: cfg.mode <= pwdata[0];
        RegSeed: cfg.seed <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[2])
      RegMode: prdata = {31'd0, cfg.mode};
      RegSeed: prdata = cfg.seed;
      default: prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/crx_setup.sv
`default_nettype none
module crx_setup
  import crx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire blk_evt_t evt,
  output setup_t        setup
);

  // byte position of the next block that needs setup values
  logic [WordW-1:0] nxt;
  logic [WordW-1:0] s1, s2, o1;
  logic [WordW-1:0] o1_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt <= '0;
    end else if (evt.start) begin
      nxt <= BlockBytes;
    end else if (evt.adv) begin
      nxt <= nxt + BlockBytes;
    end
  end

  // two-stage mix, free running; nxt holds for a whole block before use
  assign o1_rot = rotr(o1, OffsetRot2);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1        <= '0;
      s2        <= '0;
      o1        <= '0;
      setup.mix <= '0;
      setup.off <= '0;
    end else begin
      s1        <= (nxt >> 16) + nxt;
      s2        <= (nxt >> 8) + (nxt >> 24);
      o1        <= nxt + rotr(nxt, OffsetRot);
      setup.mix <= s1 + s2;
      setup.off <= o1 + o1_rot;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crx_core.sv
`default_nettype none
module crx_core
  import crx_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire setup_t setup,
  crx_in_if.sink      in_ch,
  crx_out_if.source   out_ch,
  output blk_evt_t    evt,
  output core_stat_t  stat
);

  // input register
  logic              in_full;
  logic [WordW-1:0]  in_data;
  logic              in_start;

  // cipher state
  logic [WordW-1:0]  active_seed;
  logic [WordW-1:0]  round_key;
  logic [WordW-1:0]  offset_word;
  logic [WordW-1:0]  chain_word;
  logic [IndexW-1:0] word_index;

  logic              fire;
  logic              first;
  logic [WordW-1:0]  seed_sel, key_c, off_c, chain_c, r;
  logic [IndexW-1:0] idx_c;

  assign fire        = in_full && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data  <= in_ch.data_word;
      in_start <= in_ch.stream_start;
    end
  end

  // word transform; a stream start sets up block zero, whose mix and offset are zero
  always_comb begin
    first    = in_start || (word_index == '0);
    seed_sel = in_start ? (cfg.mode ? cfg.seed : (in_data ^ SeedMark)) : active_seed;
    key_c    = first ? (in_start ? seed_sel : (active_seed ^ setup.mix)) : round_key;
    off_c    = first ? (in_start ? '0 : setup.off) : offset_word;
    chain_c  = first ? '0 : chain_word;
    idx_c    = in_start ? '0 : word_index;
    r        = in_data ^ chain_c ^ key_c ^ off_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_seed <= '0;
      round_key   <= '0;
      offset_word <= '0;
      chain_word  <= '0;
      word_index  <= '0;
    end else if (fire) begin
      active_seed <= seed_sel;
      round_key   <= rotr(key_c, KeyRot);
      chain_word  <= rotr(cfg.mode ? r : in_data, ChainRot);
      offset_word <= off_c + OffsetStep;
      word_index  <= idx_c + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (fire) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.result_word <= r;
      out_ch.block_end   <= (idx_c == LastIndex);
    end
  end

  assign evt.start       = fire && in_start;
  assign evt.adv         = fire && !in_start && (word_index == '0);
  assign stat.in_full    = in_full;
  assign stat.word_index = word_index;

endmodule
`default_nettype wire

FILE: rtl/chained_rotating_xor_block_cipher.sv
// Path: an accepted input word waits in the input register and moves on to the output
// register once that register is empty or being read.
// Throughput: one word per cycle unless output stalls; key, chain, offset step per word.
// Block setup values come from a two-stage pipeline run ahead on the next block position.
// Reset (rst, synchronous): clears mode, seed, cipher state and the position; both
// the input and the output register come up empty.
`default_nettype none
module chained_rotating_xor_block_cipher
  import crx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  crx_in_if.sink                 in_ch,
  crx_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  cfg_t       cfg;
  setup_t     setup;
  blk_evt_t   evt;
  core_stat_t stat;

  crx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crx_setup u_setup (
    .clk   (clk),
    .rst   (rst),
    .evt   (evt),
    .setup (setup)
  );

  crx_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .setup  (setup),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .evt    (evt),
    .stat   (stat)
  );

  // an accepted word lands in the input register
  a_in_load: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> stat.in_full)
    else $error("accepted word not held in input register");

  // a waiting word moves on when the output register is empty
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    stat.in_full && !out_ch.valid |=> out_ch.valid)
    else $error("pipeline stalled with empty output register");

  // the word index is back at zero while the last word of a block waits
  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.block_end |-> stat.word_index == '0)
    else $error("word index not wrapped at block end");

endmodule
`default_nettype wire

FILE: test/crx_checker.sv
`timescale 1ns / 1ps
module crx_checker
  import crx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  crx_in_if                 in_mon,
  crx_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fails,
  output int                outstanding
);

  localparam logic [PaddrW-1:0] ModeAddr = {RegMode, 2'b00};
  localparam logic [PaddrW-1:0] SeedAddr = {RegSeed, 2'b00};

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } cipher_out_t;

  // shadow registers
  logic             mode_bit;
  logic [WordW-1:0] seed_reg;

  // shadow cipher state
  logic [WordW-1:0]  stream_seed;
  logic [WordW-1:0]  key_word;
  logic [WordW-1:0]  pad_word;
  logic [WordW-1:0]  chain_word;
  logic [WordW-1:0]  block_base;
  logic [IndexW-1:0] word_pos;

  cipher_out_t pending_words[$];
  int          err_count = 0;

  function automatic logic [WordW-1:0] ror32(input logic [WordW-1:0] v, input int unsigned n);
    logic [2*WordW-1:0] twice;
    twice = {v, v};
    return twice[n +: WordW];
  endfunction

  // advance the shadow cipher by one input word and queue the expected output word
  task automatic cipher_step(input logic [WordW-1:0] d, input logic first);
    logic [WordW-1:0] p;
    logic [WordW-1:0] mix;
    logic [WordW-1:0] r;
    cipher_out_t      item;
    if (first) begin
      word_pos    = '0;
      block_base  = '0;
      stream_seed = mode_bit ? seed_reg : (d ^ SeedMark);
    end
    // block setup on the first word of each block
    if (word_pos == '0) begin
      p          = block_base;
      mix        = (p >> 16) + p + (p >> 8) + (p >> 24);
      key_word   = stream_seed ^ mix;
      pad_word   = p + ror32(p, OffsetRot);
      pad_word   = pad_word + ror32(pad_word, OffsetRot2);
      chain_word = '0;
    end
    r          = d ^ chain_word ^ key_word ^ pad_word;
    key_word   = ror32(key_word, KeyRot);
    // encrypt chains the ciphertext output, decrypt the ciphertext input
    chain_word = ror32(mode_bit ? r : d, ChainRot);
    pad_word   = pad_word + OffsetStep;
    word_pos   = word_pos + 1'b1;
    item.word  = r;
    item.last  = (word_pos == '0);
    if (item.last) begin
      block_base = block_base + BlockBytes;
    end
    pending_words.push_back(item);
  endtask

  task automatic check_word(input logic [WordW-1:0] w, input logic e);
    cipher_out_t exp_item;
    if (pending_words.size() == 0) begin
      $error("result_word: no word expected, got %h", w);
      err_count++;
    end else begin
      exp_item = pending_words.pop_front();
      if (w !== exp_item.word) begin
        $error("result_word: expected %h, got %h", exp_item.word, w);
        err_count++;
      end
      if (e !== exp_item.last) begin
        $error("block_end: expected %b, got %b", exp_item.last, e);
        err_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_bit    = 1'b0;
      seed_reg    = '0;
      stream_seed = '0;
      key_word    = '0;
      pad_word    = '0;
      chain_word  = '0;
      block_base  = '0;
      word_pos    = '0;
      pending_words.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr == ModeAddr) begin
          mode_bit = pwdata[0];
        end else if (paddr == SeedAddr) begin
          seed_reg = pwdata;
        end
      end
      // output side first: a word out always belongs to an older input
      if (out_mon.valid && out_mon.ready) begin
        check_word(out_mon.result_word, out_mon.block_end);
      end
      if (in_mon.valid && in_mon.ready) begin
        cipher_step(in_mon.data_word, in_mon.stream_start);
      end
    end
    fails       <= err_count;
    outstanding <= pending_words.size();
  end

endmodule

FILE: test/chained_rotating_xor_block_cipher_tb.sv
`timescale 1ns / 1ps
module chained_rotating_xor_block_cipher_tb;
  import crx_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int RandomWords = 1350;

  localparam logic [PaddrW-1:0] ModeAddr = {RegMode, 2'b00};
  localparam logic [PaddrW-1:0] SeedAddr = {RegSeed, 2'b00};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fails;
  int outstanding;
  int send_idle = 31;
  int recv_idle = 56;
  int words_sent = 0;
  int quiet_cycles = 0;

  crx_in_if  in_ch ();
  crx_out_if out_ch ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chained_rotating_xor_block_cipher DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  crx_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .fails       (fails),
    .outstanding (outstanding)
  );

  // output side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rand_data();
    case ($urandom_range(15))
      0: begin
        return 32'h0000_0000;
      end
      1: begin
        return 32'hFFFF_FFFF;
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  // send one word; returns at the edge where it is taken
  task automatic put_word(input logic [31:0] d, input logic s);
    if (words_sent < RandomWords / 3) begin
      send_idle = 31;
      recv_idle = 56;
    end else if (words_sent < 2 * RandomWords / 3) begin
      send_idle = 56;
      recv_idle = 31;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_word    <= d;
    in_ch.stream_start <= s;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  // stop sending and wait for every outstanding word
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic reg_write(input logic [PaddrW-1:0] a, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int   len;
    int   goal;
    logic fresh;
    logic [31:0] seed_val;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.data_word    <= '0;
    in_ch.stream_start <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // no stream start since reset: decrypt with a zero seed
    put_word(32'h0000_0000, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h1234_5678, 1'b0);
    drain();

    // encrypt with an all-ones seed
    reg_write(ModeAddr, 32'd1);
    reg_write(SeedAddr, 32'hFFFF_FFFF);
    put_word(32'h0000_0000, 1'b1);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h8000_0000, 1'b0);
    put_word(32'h0000_0001, 1'b0);
    drain();

    // mode flips mid-stream: seed held, chain now follows the input word
    reg_write(ModeAddr, 32'd0);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'h0000_0000, 1'b0);
    put_word(32'hA5A5_A5A5, 1'b0);

    // decrypt starts: seed word that cancels the mark, then all ones; a new start, then zero
    put_word(SeedMark, 1'b1);
    put_word(32'hFFFF_FFFF, 1'b0);
    put_word(32'hFFFF_FFFF, 1'b1);
    put_word(32'h0000_0000, 1'b0);
    drain();

    // encrypt with a zero seed, back-to-back stream starts
    reg_write(ModeAddr, 32'd1);
    reg_write(SeedAddr, 32'h0000_0000);
    put_word(32'hFFFF_FFFF, 1'b1);
    put_word(32'h0000_0000, 1'b1);
    put_word(32'h5A5A_5A5A, 1'b0);

    // random segments, each under its own register setting
    goal = words_sent + RandomWords;
    while (words_sent < goal) begin
      drain();
      reg_write(ModeAddr, 32'($urandom_range(1)));
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(7))
          0: seed_val = 32'h0000_0000;
          1: seed_val = 32'hFFFF_FFFF;
          default: seed_val = $urandom();
        endcase
        reg_write(SeedAddr, seed_val);
      end
      // most segments open a fresh stream; the rest carry on the old one
      fresh = ($urandom_range(3) != 0);
      len = ($urandom_range(99) < 25) ? $urandom_range(1, 8) : $urandom_range(100, 300);
      for (int i = 0; i < len && words_sent < goal; i++) begin
        put_word(rand_data(), (i == 0) ? fresh : ($urandom_range(199) == 0));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/crx_pkg.sv
rtl/crx_if.sv
rtl/crx_regs.sv
rtl/crx_setup.sv
rtl/crx_core.sv
rtl/chained_rotating_xor_block_cipher.sv
test/crx_checker.sv
test/chained_rotating_xor_block_cipher_tb.sv
